### src/bpa_pkg.sv
// Shared constants and types for the bitmap page allocator.
package bpa_pkg;
    localparam int NUM_PAGES   = 65536;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int WORD_W      = 8;
    localparam int WORD_SHIFT  = $clog2(WORD_W);
    localparam int NUM_WORDS   = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W     = $clog2(NUM_WORDS);
    localparam int IDX_W       = $clog2(NUM_PAGES) + 1;
    localparam int IDX64_W     = 48;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_OOM       = 3'd2;
    localparam logic [2:0] ST_NULL      = 3'd3;
    localparam logic [2:0] ST_UNALIGNED = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;
    localparam logic [2:0] ST_RESERVED  = 3'd6;
    localparam logic [2:0] ST_FREE      = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [27:0] result_address;
        logic [17:0] free_total;
        logic [17:0] used_total;
        logic [16:0] reserved_pages;
        logic [16:0] usable_pages;
    } t_result;
endpackage

### src/bpa_ram.sv
// Generic single-port RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

### src/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: sequencer over two bitmap RAMs.
// A clearing pass over all NUM_PAGES/8 words follows reset, then items are taken.
// Allocate scans 8-frame words, up to twice over the span, then marks the run's words.
// Free reads and updates one word, unless rejected before the read. Reserve and release
// read and write each word touched. One item is in work at a time, the next is taken
// the cycle after its result is registered. Reset is synchronous, active low.
module bitmap_page_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // address, byte_length, page_count (low up)
    input  logic [1:0]   s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // status, result_address, free_total,
                                         // used_total, reserved_pages, usable_pages
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [16:0]  i_cfg_data      // span_pages
);
    localparam int IW = bpa_pkg::IDX_W;
    localparam int WA = bpa_pkg::WADDR_W;
    localparam int WW = bpa_pkg::WORD_W;
    localparam int WS = bpa_pkg::WORD_SHIFT;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_MARK  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]  r_state;
    logic [16:0] r_span;
    logic [1:0]  r_op;
    logic [27:0] r_addr;
    logic [28:0] r_blen;
    logic [16:0] r_cnt;
    logic [IW-1:0] r_hint, r_i, r_end, r_start, r_len;
    logic        r_retry, r_mark;
    logic [2:0]  r_status;
    logic [27:0] r_res;
    logic [17:0] r_free, r_used;
    logic [16:0] r_rsv, r_usable;
    logic        r_ovalid;
    bpa_pkg::t_result r_out;

    logic          we;
    logic [WA-1:0] waddr;
    logic [WW-1:0] u_wd, rv_wd, u_rd, rv_rd;

    bpa_ram #(.WIDTH(WW), .DEPTH(bpa_pkg::NUM_WORDS)) u_used (
        .i_clk(i_clk), .i_we(we), .i_addr(waddr), .i_wdata(u_wd), .o_rdata(u_rd));
    bpa_ram #(.WIDTH(WW), .DEPTH(bpa_pkg::NUM_WORDS)) u_rsvd (
        .i_clk(i_clk), .i_we(we), .i_addr(waddr), .i_wdata(rv_wd), .o_rdata(rv_rd));

    logic [IW-1:0] span_eff;
    assign span_eff = (r_span > 17'(bpa_pkg::NUM_PAGES)) ? IW'(bpa_pkg::NUM_PAGES)
                                                         : IW'(r_span);

    // word-local bit range [lo, hi) handled this visit
    logic [IW-1:0] wbase, wnext, seg_end;
    assign wbase   = {r_i[IW-1:WS], {WS{1'b0}}};
    assign wnext   = wbase + IW'(WW);
    assign seg_end = (r_end < wnext) ? r_end : wnext;

    // scan one word for a run, carrying the run length across words
    logic [IW-1:0] sc_start, sc_len;
    logic          sc_found;
    logic [WW-1:0] mk_u, mk_r;
    logic [17:0]   mk_free;
    logic [16:0]   mk_rsv;
    always_comb begin
        logic [IW-1:0] s, l, p;
        logic f;
        s = r_start; l = r_len; f = 1'b0;
        for (int b = 0; b < WW; b++) begin
            p = wbase + IW'(b);
            if (!f && p >= r_i && p < seg_end) begin
                if (!u_rd[b]) begin
                    if (l == '0) s = p;
                    l = l + 1'b1;
                    if (l == IW'(r_cnt)) f = 1'b1;
                end else begin
                    l = '0;
                end
            end
        end
        sc_start = s; sc_len = l; sc_found = f;
    end
    always_comb begin
        logic [IW-1:0] p;
        mk_u = u_rd; mk_r = rv_rd; mk_free = r_free; mk_rsv = r_rsv;
        for (int b = 0; b < WW; b++) begin
            p = wbase + IW'(b);
            if (p >= r_i && p < seg_end) begin
                case (r_op)
                    bpa_pkg::OP_ALLOC: begin
                        mk_u[b] = 1'b1;
                        mk_free = mk_free - 1'b1;
                    end
                    bpa_pkg::OP_RESERVE: begin
                        if (!rv_rd[b]) begin
                            mk_r[b] = 1'b1;
                            mk_rsv = mk_rsv + 1'b1;
                            if (!u_rd[b]) begin
                                mk_u[b] = 1'b1;
                                mk_free = mk_free - 1'b1;
                            end
                        end
                    end
                    default: begin
                        mk_u[b] = 1'b0;
                        mk_free = mk_free + 1'b1;
                    end
                endcase
            end
        end
    end

    // decode helpers
    logic [IW-1:0] page_idx;
    logic [29:0]   rsv_end_b;
    logic [IW:0]   rsv_pages;
    logic [IW:0]   rel_end;
    assign page_idx  = IW'(r_addr >> bpa_pkg::PAGE_SHIFT);
    assign rsv_end_b = 30'(r_blen) + 30'(r_addr[bpa_pkg::PAGE_SHIFT-1:0])
                     + 30'(bpa_pkg::PAGE_BYTES - 1);
    assign rsv_pages = (IW+1)'(rsv_end_b >> bpa_pkg::PAGE_SHIFT);
    assign rel_end   = (IW+1)'(page_idx) + (IW+1)'(r_op == bpa_pkg::OP_RESERVE
                                                   ? rsv_pages : (IW+1)'(r_cnt));

    logic          free_bit_u, free_bit_r;
    assign free_bit_u = u_rd[page_idx[WS-1:0]];
    assign free_bit_r = rv_rd[page_idx[WS-1:0]];

    always_comb begin
        we = 1'b0;
        waddr = r_i[WA+WS-1:WS];
        u_wd = mk_u;
        rv_wd = mk_r;
        if (r_state == S_CLR) begin
            we = 1'b1;
            u_wd = '1;
            rv_wd = '0;
        end else if (r_state == S_MARK && r_mark) begin
            we = 1'b1;
        end else if (r_state == S_EVAL && r_op == bpa_pkg::OP_FREE) begin
            u_wd = u_rd;
            u_wd[page_idx[WS-1:0]] = 1'b0;
            rv_wd = rv_rd;
            we = (r_status == bpa_pkg::ST_OK) && !free_bit_r && free_bit_u;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_out.usable_pages, r_out.reserved_pages,
                            r_out.used_total, r_out.free_total,
                            r_out.result_address, r_out.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_span <= 17'h10000; r_hint <= '0;
            r_free <= '0; r_used <= '0; r_rsv <= '0; r_usable <= '0;
            r_ovalid <= 1'b0; r_i <= '0;
        end else begin
            if (i_cfg_valid) r_span <= i_cfg_data;
            if (r_ovalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_i <= r_i + IW'(WW);
                    if (r_i[WA+WS-1:WS] == WA'(bpa_pkg::NUM_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op   <= s_axis_tuser;
                        r_addr <= s_axis_tdata[27:0];
                        r_blen <= s_axis_tdata[56:28];
                        r_cnt  <= s_axis_tdata[73:57];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_status <= bpa_pkg::ST_OK;
                    r_res <= '0;
                    r_mark <= 1'b0;
                    r_len <= '0;
                    r_start <= '0;
                    r_retry <= 1'b0;
                    r_state <= S_RD;
                    case (r_op)
                        bpa_pkg::OP_ALLOC: begin
                            r_i <= r_hint; r_end <= span_eff;
                            if (r_cnt == '0) begin
                                r_status <= bpa_pkg::ST_ZERO; r_state <= S_OUT;
                            end else if (r_hint >= span_eff) begin
                                if (r_hint != '0) begin
                                    r_retry <= 1'b1; r_hint <= '0; r_i <= '0;
                                end
                                if (span_eff == '0 || r_hint == '0) begin
                                    r_status <= bpa_pkg::ST_OOM; r_state <= S_OUT;
                                end
                            end
                        end
                        bpa_pkg::OP_FREE: begin
                            r_i <= page_idx;
                            if (r_addr == '0) begin
                                r_status <= bpa_pkg::ST_NULL; r_state <= S_OUT;
                            end else if (r_addr[bpa_pkg::PAGE_SHIFT-1:0] != '0) begin
                                r_status <= bpa_pkg::ST_UNALIGNED; r_state <= S_OUT;
                            end else if (page_idx >= span_eff) begin
                                r_status <= bpa_pkg::ST_RANGE; r_state <= S_OUT;
                            end
                        end
                        default: begin
                            r_mark <= 1'b1;
                            r_i <= page_idx;
                            r_end <= (rel_end > (IW+1)'(span_eff)) ? span_eff : IW'(rel_end);
                            if (r_op == bpa_pkg::OP_RELEASE)
                                r_usable <= ((18'(r_usable) + 18'(r_cnt)) > 18'h1FFFF)
                                          ? 17'h1FFFF : 17'(18'(r_usable) + 18'(r_cnt));
                            if (IW'(rel_end) <= page_idx && rel_end <= (IW+1)'(span_eff)
                                || page_idx >= span_eff)
                                r_state <= S_OUT;
                        end
                    endcase
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: r_state <= r_mark ? S_MARK : S_EVAL;
                S_EVAL: begin
                    if (r_op == bpa_pkg::OP_FREE) begin
                        r_state <= S_OUT;
                        if (free_bit_r) r_status <= bpa_pkg::ST_RESERVED;
                        else if (!free_bit_u) r_status <= bpa_pkg::ST_FREE;
                        else begin
                            r_free <= r_free + 1'b1;
                            r_used <= r_used - 1'b1;
                            if (page_idx < r_hint) r_hint <= page_idx;
                        end
                    end else if (sc_found) begin
                        // mark the run from its start
                        r_mark <= 1'b1;
                        r_start <= sc_start;
                        r_i <= sc_start;
                        r_end <= sc_start + IW'(r_cnt);
                        r_used <= r_used + 18'(r_cnt);
                        r_hint <= (r_cnt == 17'd1) ? sc_start : sc_start + IW'(r_cnt);
                        r_res <= 28'({sc_start, {bpa_pkg::PAGE_SHIFT{1'b0}}});
                        r_state <= S_RD;
                    end else if (seg_end >= r_end) begin
                        if (r_hint != '0 && !r_retry) begin
                            r_retry <= 1'b1; r_hint <= '0; r_i <= '0; r_len <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_hint <= '0;
                            r_status <= bpa_pkg::ST_OOM; r_state <= S_OUT;
                        end
                    end else begin
                        r_start <= sc_start; r_len <= sc_len; r_i <= wnext;
                        r_state <= S_RD;
                    end
                end
                S_MARK: begin
                    r_free <= mk_free;
                    r_rsv <= mk_rsv;
                    r_i <= wnext;
                    r_state <= (seg_end >= r_end) ? S_OUT : S_RD;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out.status <= r_status;
                        r_out.result_address <= r_res;
                        r_out.free_total <= r_free;
                        r_out.used_total <= r_used;
                        r_out.reserved_pages <= r_rsv;
                        r_out.usable_pages <= r_usable;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^s_axis_tdata[79:74];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_DEC)
        else $error("accepted item did not start decoding");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !s_axis_tready)
        else $error("item taken during clearing pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_out))
        else $error("result lost while stalled");
endmodule

### sim/alloc_checker.sv
// Checker for the page allocator: tracks the frame maps, predicts each result and compares.
`timescale 1ns / 1ps

module alloc_checker
    import bpa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // address, byte_length, page_count (low up)
    input  logic [1:0]   s_axis_tuser,   // operation
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,   // status, result_address, free_total,
                                         // used_total, reserved_pages, usable_pages
    input  logic         i_cfg_valid,
    input  logic         o_cfg_ready,
    input  logic [16:0]  i_cfg_data,     // span_pages
    output int           o_fail_count,
    output int           o_pending
);
    bit          used_map [NUM_PAGES];
    bit          rsv_map  [NUM_PAGES];
    logic [16:0] hint;
    logic [16:0] span_reg;
    logic [17:0] n_free;
    logic [17:0] n_used;
    logic [16:0] n_rsv;
    logic [16:0] n_usable;
    t_result     expected_q [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic int span_eff();
        return (span_reg > NUM_PAGES) ? NUM_PAGES : int'(span_reg);
    endfunction

    // Start of the first run of n free frames at or above from, or -1.
    function automatic int find_run(input int from, input int n, input int span);
        int start;
        int len;
        start = 0;
        len = 0;
        for (int i = from; i < span; i++) begin
            if (!used_map[i]) begin
                if (len == 0) start = i;
                len++;
                if (len == n) return start;
            end else begin
                len = 0;
            end
        end
        return -1;
    endfunction

    task automatic apply_item(input logic [1:0] op, input logic [27:0] a,
                              input logic [28:0] bl, input logic [16:0] pc,
                              output t_result r);
        int     span;
        int     s;
        int     idx;
        int     first;
        int     last_p;
        int     u;
        longint pages;
        span = span_eff();
        r = '0;
        case (op)
            OP_ALLOC: begin
                if (pc == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    s = find_run(int'(hint), int'(pc), span);
                    // retry once from frame zero
                    if (s < 0 && hint > 0) begin
                        hint = '0;
                        s = find_run(0, int'(pc), span);
                    end
                    if (s < 0) begin
                        r.status = ST_OOM;
                    end else begin
                        for (int p = 0; p < pc; p++) begin
                            used_map[s + p] = 1'b1;
                            n_free = n_free - 1'b1;
                            n_used = n_used + 1'b1;
                        end
                        hint = (pc == 1) ? s[16:0] : 17'(s + pc);
                        r.status = ST_OK;
                        r.result_address = 28'(s * PAGE_BYTES);
                    end
                end
            end
            OP_FREE: begin
                idx = int'(a) / PAGE_BYTES;
                if (a == 0) r.status = ST_NULL;
                else if (int'(a) % PAGE_BYTES != 0) r.status = ST_UNALIGNED;
                else if (idx >= span) r.status = ST_RANGE;
                else if (rsv_map[idx]) r.status = ST_RESERVED;
                else if (!used_map[idx]) r.status = ST_FREE;
                else begin
                    used_map[idx] = 1'b0;
                    n_free = n_free + 1'b1;
                    n_used = n_used - 1'b1;
                    if (idx < hint) hint = idx[16:0];
                end
            end
            OP_RESERVE: begin
                first = int'(a) / PAGE_BYTES;
                pages = (longint'(bl) + int'(a) % PAGE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
                last_p = (first + pages > span) ? span : int'(first + pages);
                for (int i = first; i < last_p; i++) begin
                    if (!rsv_map[i]) begin
                        rsv_map[i] = 1'b1;
                        if (!used_map[i]) begin
                            used_map[i] = 1'b1;
                            n_free = n_free - 1'b1;
                        end
                        n_rsv = n_rsv + 1'b1;
                    end
                end
            end
            default: begin
                first = int'(a) / PAGE_BYTES;
                last_p = (first + int'(pc) > span) ? span : first + int'(pc);
                for (int i = first; i < last_p; i++) begin
                    used_map[i] = 1'b0;
                    n_free = n_free + 1'b1;
                end
                u = int'(n_usable) + int'(pc);
                n_usable = (u > 131071) ? 17'h1FFFF : u[16:0];
            end
        endcase
        r.free_total = n_free;
        r.used_total = n_used;
        r.reserved_pages = n_rsv;
        r.usable_pages = n_usable;
    endtask

    task automatic check_field(input string name, input longint want, input longint seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result r;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PAGES; i++) begin
                used_map[i] = 1'b1;
                rsv_map[i] = 1'b0;
            end
            hint = '0;
            span_reg = 17'd65536;
            n_free = '0;
            n_used = '0;
            n_rsv = '0;
            n_usable = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) span_reg = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(s_axis_tuser, s_axis_tdata[27:0], s_axis_tdata[56:28],
                           s_axis_tdata[73:57], r);
                expected_q.push_back(r);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tdata[2:0];
                got.result_address = m_axis_tdata[30:3];
                got.free_total = m_axis_tdata[48:31];
                got.used_total = m_axis_tdata[66:49];
                got.reserved_pages = m_axis_tdata[83:67];
                got.usable_pages = m_axis_tdata[100:84];
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected: status %0d", got.status);
                    o_fail_count++;
                end else begin
                    r = expected_q.pop_front();
                    check_field("status", r.status, got.status);
                    check_field("result_address", r.result_address, got.result_address);
                    check_field("free_total", $signed(r.free_total), $signed(got.free_total));
                    check_field("used_total", $signed(r.used_total), $signed(got.used_total));
                    check_field("reserved_pages", r.reserved_pages, got.reserved_pages);
                    check_field("usable_pages", r.usable_pages, got.usable_pages);
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

### sim/tb_top.sv
// Top of the page allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import bpa_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;   // address, byte_length, page_count (low up)
    logic [1:0]   s_axis_tuser = OP_ALLOC;   // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;   // status, result_address, free_total,
                                  // used_total, reserved_pages, usable_pages
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [16:0]  i_cfg_data = 17'd65536;   // span_pages

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int spans_run = 0;
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    bitmap_page_allocator uut (.*);

    alloc_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #50ms;
        $display("Timeout with %0d items still expected", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [27:0] a,
                             input logic [28:0] bl, input logic [16:0] pc);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, pc, bl, a};
        s_axis_tuser <= op;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        items_sent++;
    endtask

    // Hold the sender until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_span(input logic [16:0] v);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        spans_run++;
    endtask

    task automatic rand_item(input int span);
        int          sp;
        int          r;
        int          pg;
        logic [1:0]  op;
        logic [27:0] a;
        logic [28:0] bl;
        logic [16:0] pc;
        sp = (span < 1) ? 1 : span;
        pg = $urandom_range(0, (sp > 65535) ? 65535 : sp);
        a = 28'(pg * PAGE_BYTES);
        bl = '0;
        pc = '0;
        r = $urandom_range(99);
        if (r < 5) begin
            op = 2'($urandom_range(3));
            a = 28'($urandom);
            bl = 29'($urandom_range(0, 268435456));
            pc = 17'($urandom_range(0, (sp > 4096) ? 64 : 65536));
        end else if (r < 40) begin
            op = OP_ALLOC;
            if ($urandom_range(99) < 4) pc = '0;
            else if ($urandom_range(99) < 85) pc = 17'($urandom_range(1, 3));
            else pc = 17'($urandom_range(1, (sp > 512) ? 64 : sp / 2 + 1));
        end else if (r < 70) begin
            op = OP_FREE;
            if ($urandom_range(99) < 10) a = a + 28'($urandom_range(1, PAGE_BYTES - 1));
        end else if (r < 80) begin
            op = OP_RESERVE;
            a = a + 28'($urandom_range(0, PAGE_BYTES - 1));
            bl = 29'($urandom_range(0, 3 * PAGE_BYTES));
        end else begin
            op = OP_RELEASE;
            if ($urandom_range(99) < 20) a = a + 28'($urandom_range(0, PAGE_BYTES - 1));
            pc = 17'($urandom_range(0, 8));
        end
        send_item(op, a, bl, pc);
    endtask

    initial begin
        int spans [9] = '{16, 100, 1, 0, 300, 8, 1024, 33, 65536};
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the full span after reset
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd0);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd1);
        send_item(OP_RELEASE, 28'd0, 29'd0, 17'd64);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd1);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd3);
        send_item(OP_FREE, 28'd0, 29'd0, 17'd0);
        send_item(OP_FREE, 28'h1001, 29'd0, 17'd0);
        send_item(OP_FREE, 28'h2000, 29'd0, 17'd0);
        send_item(OP_FREE, 28'h2000, 29'd0, 17'd0);
        send_item(OP_RESERVE, 28'h5064, 29'd5000, 17'd0);
        send_item(OP_FREE, 28'h5000, 29'd0, 17'd0);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd60);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd2);
        send_item(OP_RELEASE, 28'hFFFF000, 29'd0, 17'd65536);
        send_item(OP_RELEASE, 28'hFFFFFFF, 29'd0, 17'd1);
        send_item(OP_RELEASE, 28'hFFFFFFF, 29'h1FFFFFFF, 17'd65536);
        send_item(OP_RESERVE, 28'hFFFFFFF, 29'd268435456, 17'd0);
        send_item(OP_ALLOC, 28'hFFFFFFF, 29'd0, 17'd65536);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd1);
        send_item(OP_FREE, 28'hFFFF000, 29'd0, 17'd0);
        send_item(OP_FREE, 28'h0001000, 29'd0, 17'd0);
        send_item(OP_ALLOC, 28'd0, 29'd0, 17'd1);

        for (int ph = 0; ph < 9; ph++) begin
            write_span(17'(spans[ph]));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            if (ph == 0) begin
                send_item(OP_FREE, 28'(16 * PAGE_BYTES), 29'd0, 17'd0);
            end
            // open the span up so that allocations can succeed
            send_item(OP_RELEASE, 28'd0, 29'd0, 17'(spans[ph]));
            n = (spans[ph] == 65536) ? 60 : 150;
            for (int k = 0; k < n; k++) begin
                if (ph == 1 && k == 40) begin
                    @(negedge i_clk);
                    hold_go = ~hold_go;
                    @(posedge i_clk);
                end
                if (ph == 2 && k == 70) drain();
                rand_item(spans[ph]);
            end
        end
        idle_pct = 0;
        stall_pct = 0;

        drain();
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d items over %0d span settings, with idle, stall and hold-off",
                 items_sent, spans_run);
        $display("phases.");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### files.f
src/bpa_pkg.sv
src/bpa_ram.sv
src/bitmap_page_allocator.sv
sim/alloc_checker.sv
sim/tb_top.sv
